@@ hw/rtl/m3inv_pkg.sv @@
// Shared types, constants and cofactor wiring for the 3x3 matrix inverse.
`timescale 1ns / 1ps

package m3inv_pkg;

	localparam int WORD_BITS = 32;
	localparam int NUM_LANES = 9;
	localparam int NUM_TERMS = 4;
	localparam int LANE_LAT  = WORD_BITS + 4;

	typedef logic signed [WORD_BITS-1:0]   word_t;
	typedef logic signed [2*WORD_BITS-1:0] prod_t;
	typedef logic signed [2*WORD_BITS:0]   cof_t;
	typedef logic [2*WORD_BITS:0]          num_t;

	localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

	// cofactor k = elem[p] * elem[q] - elem[r] * elem[s], elements in row-major order
	localparam logic [3:0] COF_IDX [NUM_LANES][NUM_TERMS] = '{
		'{4'd4, 4'd8, 4'd7, 4'd5}, '{4'd7, 4'd2, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd4, 4'd2},
		'{4'd6, 4'd5, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd6, 4'd2}, '{4'd3, 4'd2, 4'd0, 4'd5},
		'{4'd3, 4'd7, 4'd6, 4'd4}, '{4'd6, 4'd1, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd3, 4'd1}
	};

	typedef struct packed {
		logic [WORD_BITS-1:0] rem;
		logic [WORD_BITS-1:0] nq;
		logic [WORD_BITS:0]   den;
		logic                 qneg;
		logic                 ovf;
		logic                 sing;
	} div_t;

	typedef struct packed {
		logic [WORD_BITS-1:0] q;
		logic                 qneg;
		logic                 ovf;
		logic                 sing;
	} lane_res_t;

	typedef struct packed {
		word_t a00;
		word_t a01;
		word_t a02;
		word_t a10;
		word_t a11;
		word_t a12;
		word_t a20;
		word_t a21;
		word_t a22;
		word_t det;
	} mat_t;

	typedef struct packed {
		word_t b00;
		word_t b01;
		word_t b02;
		word_t b10;
		word_t b11;
		word_t b12;
		word_t b20;
		word_t b21;
		word_t b22;
		logic  singular;
		logic  overflow;
	} inv_t;

endpackage

@@ hw/rtl/m3inv_div_step.sv @@
// One restoring division step: one quotient bit, registered.
`timescale 1ns / 1ps

module m3inv_div_step (
	input  logic              clk,
	input  logic              en,
	input  m3inv_pkg::div_t   d,
	output m3inv_pkg::div_t   stage_q
);

	logic [m3inv_pkg::WORD_BITS:0]   r2;
	logic [m3inv_pkg::WORD_BITS:0]   diff;
	logic                            ge;
	m3inv_pkg::div_t                 nxt;

	always_comb begin
		r2   = {d.rem, d.nq[m3inv_pkg::WORD_BITS-1]};
		ge   = r2 >= d.den;
		diff = r2 - d.den;
		nxt  = d;
		nxt.rem = ge ? diff[m3inv_pkg::WORD_BITS-1:0] : r2[m3inv_pkg::WORD_BITS-1:0];
		nxt.nq  = {d.nq[m3inv_pkg::WORD_BITS-2:0], ge};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stage_q <= nxt;
		end
	end

endmodule

@@ hw/rtl/m3inv_lane.sv @@
// One inverse element: cofactor products, rounded numerator and divider chain.
`timescale 1ns / 1ps

module m3inv_lane (
	input  logic                  clk,
	input  logic                  en,
	input  m3inv_pkg::word_t      p,
	input  m3inv_pkg::word_t      q,
	input  m3inv_pkg::word_t      r,
	input  m3inv_pkg::word_t      s,
	input  m3inv_pkg::word_t      det,
	output m3inv_pkg::lane_res_t  res
);

	localparam int W = m3inv_pkg::WORD_BITS;

	m3inv_pkg::prod_t      prod0_s1;
	m3inv_pkg::prod_t      prod1_s1;
	logic [W-1:0]          dmag_s1;
	logic                  dneg_s1;
	logic                  sing_s1;

	m3inv_pkg::cof_t       cof_s2;
	logic [W-1:0]          dmag_s2;
	logic                  dneg_s2;
	logic                  sing_s2;

	m3inv_pkg::num_t       num_s3;
	logic [W:0]            den_s3;
	logic                  qneg_s3;
	logic                  sing_s3;

	m3inv_pkg::num_t       cof2;
	m3inv_pkg::num_t       dext;
	m3inv_pkg::num_t       num_c;
	logic [W:0]            rem0;
	logic                  big;
	m3inv_pkg::div_t       d0_c;
	m3inv_pkg::div_t       d0_s4;
	m3inv_pkg::div_t       stg [W+1];

	// products and determinant magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			prod0_s1 <= m3inv_pkg::prod_t'(p) * m3inv_pkg::prod_t'(q);
			prod1_s1 <= m3inv_pkg::prod_t'(r) * m3inv_pkg::prod_t'(s);
			dneg_s1  <= det[W-1];
			dmag_s1  <= det[W-1] ? (~det + 1'b1) : det;
			sing_s1  <= det == '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cof_s2  <= m3inv_pkg::cof_t'(prod0_s1) - m3inv_pkg::cof_t'(prod1_s1);
			dmag_s2 <= dmag_s1;
			dneg_s2 <= dneg_s1;
			sing_s2 <= sing_s1;
		end
	end

	// numerator 2*|cof| + |det| in one add or subtract
	always_comb begin
		cof2  = {cof_s2[2*W-1:0], 1'b0};
		dext  = m3inv_pkg::num_t'(dmag_s2);
		num_c = cof_s2[2*W] ? (dext - cof2) : (cof2 + dext);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s3  <= num_c;
			den_s3  <= {dmag_s2, 1'b0};
			qneg_s3 <= cof_s2[2*W] ^ dneg_s2;
			sing_s3 <= sing_s2;
		end
	end

	// quotient of WORD_BITS or more bits is out of range
	always_comb begin
		rem0      = num_s3[2*W:W];
		big       = rem0 >= den_s3;
		d0_c.rem  = big ? '0 : rem0[W-1:0];
		d0_c.nq   = num_s3[W-1:0];
		d0_c.den  = den_s3;
		d0_c.qneg = qneg_s3;
		d0_c.ovf  = big;
		d0_c.sing = sing_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d0_s4 <= d0_c;
		end
	end

	assign stg[0] = d0_s4;

	for (genvar k = 1; k <= W; k++) begin : g_step
		m3inv_div_step u_step (
			.clk     (clk),
			.en      (en),
			.d       (stg[k-1]),
			.stage_q (stg[k])
		);
	end

	always_comb begin
		res.q    = stg[W].nq;
		res.qneg = stg[W].qneg;
		res.ovf  = stg[W].ovf;
		res.sing = stg[W].sing;
	end

endmodule

@@ hw/rtl/m3inv_merge.sv @@
// Lane merge: sign, saturation, singular handling, output register and skid stage.
`timescale 1ns / 1ps

module m3inv_merge (
	input  logic                  clk,
	input  logic                  arst_n,
	input  m3inv_pkg::lane_res_t  lanes [m3inv_pkg::NUM_LANES],
	input  logic                  tail_vld,
	input  logic                  stall,
	output m3inv_pkg::inv_t       inv,
	output logic                  inv_vld,
	output logic                  skid_full
);

	localparam int W = m3inv_pkg::WORD_BITS;

	m3inv_pkg::word_t  vals [m3inv_pkg::NUM_LANES];
	logic              any_ovf;
	logic              sing;
	logic              sat;
	m3inv_pkg::inv_t   res;
	m3inv_pkg::inv_t   out_q;
	m3inv_pkg::inv_t   skid_q;
	logic              out_vld_q;
	logic              skid_vld_q;
	logic              take;

	always_comb begin
		sing    = lanes[0].sing;
		any_ovf = 1'b0;
		sat     = 1'b0;
		for (int k = 0; k < m3inv_pkg::NUM_LANES; k++) begin
			sat = lanes[k].ovf ||
			      (lanes[k].q[W-1] && (!lanes[k].qneg || (lanes[k].q[W-2:0] != '0)));
			if (sing) begin
				vals[k] = '0;
			end else if (sat) begin
				vals[k] = lanes[k].qneg ? m3inv_pkg::WORD_MIN : m3inv_pkg::WORD_MAX;
			end else begin
				vals[k] = lanes[k].qneg ? (~lanes[k].q + 1'b1) : lanes[k].q;
			end
			any_ovf = any_ovf | sat;
		end
		res.b00      = vals[0];
		res.b01      = vals[1];
		res.b02      = vals[2];
		res.b10      = vals[3];
		res.b11      = vals[4];
		res.b12      = vals[5];
		res.b20      = vals[6];
		res.b21      = vals[7];
		res.b22      = vals[8];
		res.singular = sing;
		res.overflow = any_ovf && !sing;
	end

	assign take = !out_vld_q || !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (take) begin
			out_vld_q  <= skid_vld_q || tail_vld;
			skid_vld_q <= 1'b0;
		end else if (tail_vld && !skid_vld_q) begin
			skid_vld_q <= 1'b1;
		end
	end

	// hold the output while stalled, park the next transfer in the skid stage
	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= skid_vld_q ? skid_q : res;
		end else if (tail_vld && !skid_vld_q) begin
			skid_q <= res;
		end
	end

	assign inv       = out_q;
	assign inv_vld   = out_vld_q;
	assign skid_full = skid_vld_q;

endmodule

@@ hw/rtl/matrix3_inverse.sv @@
// 3x3 matrix inverse by adjugate over determinant, signed fixed point, nine parallel lanes.
// Registered path: products, cofactor, numerator, divider setup, divider steps, merge output.
// Throughput: one matrix per cycle while mat_stall is low; each lane's divider is a chain of WORD_BITS
// one-bit restoring steps, each in its own stage, so every stage takes a new item each cycle unless stalled.
// Reset clears the valid pipeline and the output and skid valid flags; data registers are not reset.
`timescale 1ns / 1ps

module matrix3_inverse (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               mat_valid,
	output logic               mat_stall,
	input  m3inv_pkg::mat_t    mat,
	output logic               inv_valid,
	input  logic               inv_stall,
	output m3inv_pkg::inv_t    inv
);

	localparam int LAT = m3inv_pkg::LANE_LAT;

	m3inv_pkg::word_t      elem [m3inv_pkg::NUM_LANES];
	m3inv_pkg::lane_res_t  lanes [m3inv_pkg::NUM_LANES];
	logic [LAT-1:0]        vld_s;
	logic                  skid_full;
	logic                  en;
	logic                  accept;

	assign elem[0] = mat.a00;
	assign elem[1] = mat.a01;
	assign elem[2] = mat.a02;
	assign elem[3] = mat.a10;
	assign elem[4] = mat.a11;
	assign elem[5] = mat.a12;
	assign elem[6] = mat.a20;
	assign elem[7] = mat.a21;
	assign elem[8] = mat.a22;

	assign en        = !skid_full;
	assign mat_stall = skid_full;
	assign accept    = mat_valid && !skid_full;

	// advance the valid pipeline with the lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-2:0], accept};
		end
	end

	for (genvar k = 0; k < m3inv_pkg::NUM_LANES; k++) begin : g_lane
		m3inv_lane u_lane (
			.clk (clk),
			.en  (en),
			.p   (elem[m3inv_pkg::COF_IDX[k][0]]),
			.q   (elem[m3inv_pkg::COF_IDX[k][1]]),
			.r   (elem[m3inv_pkg::COF_IDX[k][2]]),
			.s   (elem[m3inv_pkg::COF_IDX[k][3]]),
			.det (mat.det),
			.res (lanes[k])
		);
	end

	m3inv_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.lanes     (lanes),
		.tail_vld  (vld_s[LAT-1]),
		.stall     (inv_stall),
		.inv       (inv),
		.inv_vld   (inv_valid),
		.skid_full (skid_full)
	);

endmodule
